/* rtl/core/stable_priority_interrupt_queue_defines.svh */
// ----------------------------------------------------------------------------
// Stable priority interrupt queue: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_INTERRUPT_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_INTERRUPT_QUEUE_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define SPIQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle
`define SPIQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/spiq_pkg.sv */
// ----------------------------------------------------------------------------
// Stable priority interrupt queue package
// Sizes, item types and cell control shared by the queue modules.
// ----------------------------------------------------------------------------
package spiq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PRIO_BITS   = 8;
  localparam int unsigned ID_BITS     = 8;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POPPED    = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef struct packed {
    logic [ID_BITS-1:0]   src;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    mode_e                mode;
    logic [ID_BITS-1:0]   source_id;
    logic [PRIO_BITS-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [ID_BITS-1:0]   out_source;
    logic [PRIO_BITS-1:0] out_priority;
    logic [CNT_W-1:0]     fill_level;
  } out_item_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } cell_cmd_t;

endpackage

/* rtl/core/spiq_cell.sv */
// ----------------------------------------------------------------------------
// Queue cell
// One sorted slot: compares its priority with the incoming one and takes
// the new entry, its left neighbour, its right neighbour, or holds.
// ----------------------------------------------------------------------------
module spiq_cell (
  input  logic                clk_i,
  input  spiq_pkg::cell_cmd_t cmd_i,
  input  logic                occ_i,
  input  logic                tail_i,
  input  logic                left_gt_i,
  input  spiq_pkg::entry_t    left_entry_i,
  input  spiq_pkg::entry_t    right_entry_i,
  output logic                gt_o,
  output spiq_pkg::entry_t    entry_o
);

  spiq_pkg::entry_t entry_q, entry_d;

  assign gt_o    = occ_i && (entry_q.prio > cmd_i.entry.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    priority if (cmd_i.pop) begin
      entry_d = right_entry_i;
    end else if (cmd_i.push) begin
      // everything from the insertion point onwards moves one slot back
      priority if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o || tail_i) begin
        entry_d = cmd_i.entry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* rtl/core/spiq_out_buf.sv */
// ----------------------------------------------------------------------------
// Result buffer
// Output register plus one skid slot, so a new item is taken while a
// result waits on a stalled consumer.
// ----------------------------------------------------------------------------
module spiq_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  spiq_pkg::out_item_t wr_item_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spiq_pkg::out_item_t out_item_o
);

  logic                o_valid_q, o_valid_d;
  logic                s_valid_q, s_valid_d;
  spiq_pkg::out_item_t o_item_q, o_item_d;
  spiq_pkg::out_item_t s_item_q, s_item_d;

  assign full_o      = s_valid_q;
  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_item_q;

  always_comb begin
    o_valid_d = o_valid_q;
    s_valid_d = s_valid_q;
    o_item_d  = o_item_q;
    s_item_d  = s_item_q;
    if (o_valid_q && out_stall_i) begin
      if (wr_i) begin
        s_valid_d = 1'b1;
        s_item_d  = wr_item_i;
      end
    end else if (s_valid_q) begin
      o_valid_d = 1'b1;
      o_item_d  = s_item_q;
      s_valid_d = 1'b0;
    end else begin
      o_valid_d = wr_i;
      o_item_d  = wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_item_q <= o_item_d;
    s_item_q <= s_item_d;
  end

endmodule

/* rtl/core/stable_priority_interrupt_queue.sv */
// Result: the result of an accepted item is registered in the output register or the skid slot.
// Throughput: one push or pop per cycle while the skid slot is free; every cell of the chain compares
//   and shifts in the same cycle, so no operation iterates.
// Reset: asynchronous, active low; clears the fill count and the result
//   buffer. Cell contents are left as they are and only occupied cells
//   are ever read, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Stable priority interrupt queue
// Sorted chain of cells; a push enters after all entries of equal or
// lower priority number, a pop takes the front entry.
// ----------------------------------------------------------------------------
`include "stable_priority_interrupt_queue_defines.svh"

module stable_priority_interrupt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spiq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spiq_pkg::out_item_t out_item_o
);

  localparam int unsigned Depth = spiq_pkg::QUEUE_DEPTH;
  localparam int unsigned CntW  = spiq_pkg::CNT_W;

  // Fill count: cells below it hold valid entries, front at cell 0
  logic [CntW-1:0] count_q, count_d;

  logic in_fire, is_push, is_pop, full, empty, push_ok, pop_ok;

  spiq_pkg::cell_cmd_t cmd;
  spiq_pkg::out_item_t res;

  logic             gt    [Depth];
  spiq_pkg::entry_t entry [Depth];

  // Items are taken while the skid slot is free
  assign in_fire = in_valid_i && !in_stall_o;
  assign is_push = (in_item_i.mode == spiq_pkg::MODE_PUSH);
  assign is_pop  = (in_item_i.mode == spiq_pkg::MODE_POP);
  assign full    = (count_q == CntW'(Depth));
  assign empty   = (count_q == '0);
  assign push_ok = in_fire && is_push && !full;
  assign pop_ok  = in_fire && is_pop && !empty;

  assign cmd.push       = push_ok;
  assign cmd.pop        = pop_ok;
  assign cmd.entry.src  = in_item_i.source_id;
  assign cmd.entry.prio = in_item_i.priority_req;

  // Cell chain: left neighbour feeds on insert, right neighbour on pop.
  // The last cell refills from itself on pop; its value is then stale
  // but outside the fill count.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic             left_gt;
    spiq_pkg::entry_t left_entry;
    spiq_pkg::entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = entry[i];
    end else begin : g_mid
      assign left_gt    = gt[i-1];
      assign left_entry = entry[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    spiq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (CntW'(i) < count_q),
      .tail_i        (CntW'(i) == count_q),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .gt_o          (gt[i]),
      .entry_o       (entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result item for the accepted operation
  always_comb begin
    res.out_source   = '0;
    res.out_priority = '0;
    res.fill_level   = count_d;
    unique case (in_item_i.mode)
      spiq_pkg::MODE_PUSH: begin
        res.status = full ? spiq_pkg::ST_PUSH_FULL : spiq_pkg::ST_PUSH_OK;
      end
      spiq_pkg::MODE_POP: begin
        if (empty) begin
          res.status = spiq_pkg::ST_POP_EMPTY;
        end else begin
          res.status       = spiq_pkg::ST_POPPED;
          res.out_source   = entry[0].src;
          res.out_priority = entry[0].prio;
        end
      end
      default: begin
        res.status = spiq_pkg::ST_POP_EMPTY;
      end
    endcase
  end

  spiq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (in_fire),
    .wr_item_i   (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Fill count never passes the depth
  `SPIQ_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth))
  // Accepted push grows the queue by one
  `SPIQ_ASSERT_NEXT(a_push_grow, clk_i, rst_ni, push_ok, count_q == $past(count_q) + 1'b1)
  // Accepted pop shrinks the queue by one
  `SPIQ_ASSERT_NEXT(a_pop_shrink, clk_i, rst_ni, pop_ok, count_q == $past(count_q) - 1'b1)
  // A filled skid slot means the output register is occupied too
  `SPIQ_ASSERT_SAME(a_skid_order, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule
